>>> rtl/sts_pkg.sv
// Shared constants for the fixed-point sine series block.
package sts_pkg;

    // Two pi with 60 fraction bits.
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

    // Default build parameters.
    localparam int MAX_TERMS_DEF = 16;
    localparam int FRAC_BITS_DEF = 24;

    // Register map and reset values.
    localparam int          TC_W          = 5;
    localparam logic        REG_TERM_COUNT = 1'b0;
    localparam logic [TC_W-1:0] TC_RESET  = 5'd8;

endpackage

>>> rtl/sine_taylor_series_top.sv
// Top level of the pipelined fixed-point sine series block.
// Each accepted angle (signed, FRAC_BITS fraction bits) is brought into [0, 2*pi], and then
// term_count terms of the Maclaurin series for sine are summed (a count of zero gives one
// term and a count above MAX_TERMS gives MAX_TERMS), with every term and partial sum
// saturated to 32 bits and o_saturated set when that happens. The block is a fully
// pipelined datapath: it takes one transaction per cycle while the output is not stalled.
// A result passes the entry stage, one conditional-subtract stage per quotient bit of the
// angle reduction, one stage for the reduced angle, one stage each for the square and the
// first series factor, and two stages (multiply, then round and accumulate) per series
// step. A stall on the output freezes the whole pipeline.
module sine_taylor_series_top #(
    parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_angle,
    // Output channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_sine_value,
    output logic               o_saturated
);

    localparam logic [63:0] PERIOD64 =
        (sts_pkg::TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [32:0] PERIOD = PERIOD64[32:0];
    localparam int KB  = 29 - FRAC_BITS;        // quotient bits of the reduction
    localparam int NW  = $clog2(MAX_TERMS + 1);
    localparam int X2W = FRAC_BITS + 6;
    localparam int FW  = FRAC_BITS + 4;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
    localparam logic [5:0]  MAX_N    = 6'(MAX_TERMS);
    localparam logic [63:0] D1       = 64'd6;
    localparam logic [31:0] RECIP1   = 32'(((64'd1 << 32) + D1 / 2) / D1);

    typedef struct packed {
        logic               vld;
        logic               neg;
        logic               big;
        logic signed [31:0] x;
        logic [32:0]        y;
        logic [NW-1:0]      n;
    } t_red;

    typedef struct packed {
        logic               vld;
        logic [NW-1:0]      n;
        logic [X2W-1:0]     x2;
        logic [FW-1:0]      factor;
        logic signed [31:0] term;
        logic signed [31:0] sum;
        logic               flag;
    } t_ser;

    typedef struct packed {
        logic               vld;
        logic [NW-1:0]      n;
        logic [X2W-1:0]     x2;
        logic [FW-1:0]      factor;
        logic signed [63:0] prod;
        logic signed [31:0] sum;
        logic               flag;
    } t_mul;

    localparam int TC_W_L = sts_pkg::TC_W;
    logic               en;
    logic [TC_W_L-1:0]  r_term_count;

    t_red r_red [0:KB];
    t_ser r_ser [0:MAX_TERMS-1];
    t_mul r_mul [1:MAX_TERMS-1];

    // Stage after reduction: reduced angle.
    logic               r_x_vld;
    logic [NW-1:0]      r_x_n;
    logic [31:0]        r_x;
    // Square stage.
    logic               r_sq_vld;
    logic [NW-1:0]      r_sq_n;
    logic [31:0]        r_sq_x;
    logic [X2W-1:0]     r_sq_x2;

    // The whole pipeline moves unless a finished result is held by the sink.
    assign en      = !(r_ser[MAX_TERMS-1].vld && i_stall);
    assign o_stall = !en;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= sts_pkg::TC_RESET;
        end else if (psel && penable && pwrite && paddr[2] == sts_pkg::REG_TERM_COUNT) begin
            r_term_count <= pwdata[TC_W_L-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sts_pkg::REG_TERM_COUNT) ?
                    {{(32-TC_W_L){1'b0}}, r_term_count} : 32'd0;

    // Entry stage: fold both reduction cases into one remainder problem.
    logic [5:0]    n_tc;
    logic [NW-1:0] n_n;
    logic [32:0]   n_y;
    always_comb begin
        n_tc = {1'b0, r_term_count};
        if (n_tc == 6'd0) begin
            n_n = NW'(1);
        end else if (n_tc > MAX_N) begin
            n_n = NW'(MAX_TERMS);
        end else begin
            n_n = n_tc[NW-1:0];
        end
        if (i_angle < 0) begin
            n_y = 33'(-{i_angle[31], i_angle} - 33'sd1);
        end else begin
            n_y = 33'({i_angle[31], i_angle} - 33'sd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red[0].vld <= 1'b0;
        end else if (en) begin
            r_red[0].vld <= i_valid;
        end
        if (en) begin
            r_red[0].neg <= i_angle < 0;
            r_red[0].big <= {i_angle[31], i_angle} > $signed(PERIOD);
            r_red[0].x   <= i_angle;
            r_red[0].y   <= n_y;
            r_red[0].n   <= n_n;
        end
    end

    // Restoring remainder by the period, one quotient bit per stage.
    for (genvar j = 0; j < KB; j++) begin : g_red
        localparam logic [32:0] TS = PERIOD << (KB - 1 - j);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_red[j+1].vld <= 1'b0;
            end else if (en) begin
                r_red[j+1].vld <= r_red[j].vld;
            end
            if (en) begin
                r_red[j+1].neg <= r_red[j].neg;
                r_red[j+1].big <= r_red[j].big;
                r_red[j+1].x   <= r_red[j].x;
                r_red[j+1].n   <= r_red[j].n;
                r_red[j+1].y   <= (r_red[j].y >= TS) ? r_red[j].y - TS : r_red[j].y;
            end
        end
    end

    // Reduced angle from the remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (en) begin
            r_x_vld <= r_red[KB].vld;
        end
        if (en) begin
            r_x_n <= r_red[KB].n;
            if (r_red[KB].neg) begin
                r_x <= 32'(PERIOD - 33'd1 - r_red[KB].y);
            end else if (r_red[KB].big) begin
                r_x <= 32'(r_red[KB].y + 33'd1);
            end else begin
                r_x <= r_red[KB].x;
            end
        end
    end

    // Square of the reduced angle.
    logic [63:0] n_sq;
    assign n_sq = 64'(r_x) * 64'(r_x) + HALF_LSB;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else if (en) begin
            r_sq_vld <= r_x_vld;
        end
        if (en) begin
            r_sq_n  <= r_x_n;
            r_sq_x  <= r_x;
            r_sq_x2 <= X2W'(n_sq >> FRAC_BITS);
        end
    end

    // First series factor.
    logic [X2W+31:0] n_f1;
    assign n_f1 = (X2W+32)'(r_sq_x2) * (X2W+32)'(RECIP1) + (X2W+32)'(64'd1 << 31);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser[0].vld <= 1'b0;
        end else if (en) begin
            r_ser[0].vld <= r_sq_vld;
        end
        if (en) begin
            r_ser[0].n      <= r_sq_n;
            r_ser[0].x2     <= r_sq_x2;
            r_ser[0].factor <= FW'(n_f1 >> 32);
            r_ser[0].term   <= $signed(r_sq_x);
            r_ser[0].sum    <= $signed(r_sq_x);
            r_ser[0].flag   <= 1'b0;
        end
    end

    // Series steps: multiply, then round, negate, saturate and accumulate.
    for (genvar i = 1; i < MAX_TERMS; i++) begin : g_step
        localparam logic [63:0] DN = 64'((2 * i + 2) * (2 * i + 3));
        localparam logic [31:0] RECIP_NEXT = 32'(((64'd1 << 32) + DN / 2) / DN);

        logic [X2W+31:0]    n_fn;
        logic               n_neg;
        logic [63:0]        n_mag;
        logic [63:0]        n_r;
        logic signed [63:0] n_t;
        logic signed [31:0] n_term;
        logic signed [32:0] n_s;
        logic signed [31:0] n_sum;
        logic               n_ft;
        logic               n_fs;

        assign n_fn = (X2W+32)'(r_ser[i-1].x2) * (X2W+32)'(RECIP_NEXT)
                      + (X2W+32)'(64'd1 << 31);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mul[i].vld <= 1'b0;
            end else if (en) begin
                r_mul[i].vld <= r_ser[i-1].vld;
            end
            if (en) begin
                r_mul[i].n      <= r_ser[i-1].n;
                r_mul[i].x2     <= r_ser[i-1].x2;
                r_mul[i].factor <= FW'(n_fn >> 32);
                r_mul[i].prod   <= 64'(r_ser[i-1].term) *
                                   $signed({{(64-FW){1'b0}}, r_ser[i-1].factor});
                r_mul[i].sum    <= r_ser[i-1].sum;
                r_mul[i].flag   <= r_ser[i-1].flag;
            end
        end

        always_comb begin
            n_neg = r_mul[i].prod < 0;
            n_mag = n_neg ? 64'(-r_mul[i].prod) : 64'(r_mul[i].prod);
            n_r   = (n_mag + HALF_LSB) >> FRAC_BITS;
            n_t   = n_neg ? $signed(n_r) : -$signed(n_r);
            n_ft  = 1'b0;
            if (n_t > 64'sd2147483647) begin
                n_term = 32'sh7FFFFFFF;
                n_ft   = 1'b1;
            end else if (n_t < -64'sd2147483648) begin
                n_term = 32'sh80000000;
                n_ft   = 1'b1;
            end else begin
                n_term = 32'(n_t);
            end
            n_s  = 33'(r_mul[i].sum) + 33'(n_term);
            n_fs = 1'b0;
            if (n_s > 33'sd2147483647) begin
                n_sum = 32'sh7FFFFFFF;
                n_fs  = 1'b1;
            end else if (n_s < -33'sd2147483648) begin
                n_sum = 32'sh80000000;
                n_fs  = 1'b1;
            end else begin
                n_sum = 32'(n_s);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ser[i].vld <= 1'b0;
            end else if (en) begin
                r_ser[i].vld <= r_mul[i].vld;
            end
            if (en) begin
                r_ser[i].n      <= r_mul[i].n;
                r_ser[i].x2     <= r_mul[i].x2;
                r_ser[i].factor <= r_mul[i].factor;
                if (NW'(i) < r_mul[i].n) begin
                    r_ser[i].term <= n_term;
                    r_ser[i].sum  <= n_sum;
                    r_ser[i].flag <= r_mul[i].flag | n_ft | n_fs;
                end else begin
                    r_ser[i].term <= 32'(r_mul[i].prod);
                    r_ser[i].sum  <= r_mul[i].sum;
                    r_ser[i].flag <= r_mul[i].flag;
                end
            end
        end
    end

    assign o_valid      = r_ser[MAX_TERMS-1].vld;
    assign o_sine_value = r_ser[MAX_TERMS-1].sum;
    assign o_saturated  = r_ser[MAX_TERMS-1].flag;

endmodule

>>> sim/tb_top.sv
// Testbench for the fixed-point sine series block: randomized angles checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXT = sts_pkg::MAX_TERMS_DEF;
    localparam int FB = sts_pkg::FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic signed [31:0] i_angle;
    logic        o_valid;
    logic        i_stall;
    logic signed [31:0] o_sine_value;
    logic        o_saturated;

    typedef struct packed {
        logic signed [31:0] sine_value;
        logic               saturated;
    } sine_result_t;

    logic [31:0]  angle_q[$];
    sine_result_t sine_expect_q[$];
    logic [4:0]   tc_shadow;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           mismatch_count;
    int           idle_cycles;
    bit           stim_done;

    sine_taylor_series_top u_top (.*);

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Saturate to the signed 32-bit range, flagging any clip.
    function automatic longint clip32(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Series sum of sine for one angle at the current term count.
    function automatic sine_result_t sine_series(logic [31:0] raw, logic [4:0] tc);
        longint x, t, k, term, sum, prod, mag;
        longint unsigned x2, d, rc, factor, r;
        int n;
        bit flag;
        sine_result_t res;
        flag = 1'b0;
        x = longint'(signed'(raw));
        t = longint'((sts_pkg::TWO_PI_Q60 + (64'd1 << (59 - FB))) >> (60 - FB));
        if (x < 0) begin
            k = (-x + t - 1) / t;
            x += k * t;
        end else if (x > t) begin
            k = (x - 1) / t;
            x -= k * t;
        end
        n = (tc > MAXT) ? MAXT : int'(tc);
        x2 = (longint'(unsigned'(x)) * longint'(unsigned'(x)) + (64'd1 << (FB - 1))) >> FB;
        term = x;
        sum = x;
        for (int i = 1; i < n; i++) begin
            d = longint'(unsigned'(2 * i)) * longint'(unsigned'(2 * i + 1));
            rc = ((64'd1 << 32) + d / 2) / d;
            factor = (x2 * rc + (64'd1 << 31)) >> 32;
            prod = term * longint'(factor);
            mag = (prod < 0) ? -prod : prod;
            r = (longint'(unsigned'(mag)) + (64'd1 << (FB - 1))) >> FB;
            term = clip32((prod < 0) ? longint'(r) : -longint'(r), flag);
            sum = clip32(sum + term, flag);
        end
        res.sine_value = sum[31:0];
        res.saturated = flag;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("Mismatch on %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // Driver: present queued angles, predicting each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                sine_expect_q.push_back(sine_series(i_angle, tc_shadow));
                void'(angle_q.pop_front());
            end
            if (!i_valid || !o_stall) begin
                if (i_valid && !o_stall && angle_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (i_valid && !o_stall) begin
                    if ($urandom_range(99) < send_idle_pct) begin
                        i_valid <= 1'b0;
                    end else begin
                        i_angle <= angle_q[0];
                    end
                end else if (angle_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_angle <= angle_q[0];
                end
            end
        end
    end

    // Receiver stall and result checking.
    always @(posedge i_clk) begin
        sine_result_t exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (sine_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", o_sine_value, 0);
                end else begin
                    exp_r = sine_expect_q.pop_front();
                    if (o_sine_value !== exp_r.sine_value)
                        report_mismatch("sine_value", o_sine_value, exp_r.sine_value);
                    if (o_saturated !== exp_r.saturated)
                        report_mismatch("saturated", o_saturated, exp_r.saturated);
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog over cycles with no accepted transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || stim_done) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(4 * sts_pkg::REG_TERM_COUNT)) tc_shadow = data[4:0];
    endtask

    // Wait until all queued angles are sent and every result is back, plus pipeline drain.
    task automatic drain_results();
        while (angle_q.size() > 0 || i_valid || sine_expect_q.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_angle();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($urandom_range(32'd105414357));
            2: return -32'($urandom_range(32'd105414357));
            3: return 32'($urandom_range(32'd210828714)) - 32'd105414357;
            default: return {{8{1'($urandom_range(1))}}, 24'($urandom())};
        endcase
    endfunction

    // Stimulus sequence: directed cases, then random phases at several term counts.
    initial begin
        logic [4:0] tc_list[8];
        int idle_list[4];
        int stall_list[4];
        tc_list = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd8, 5'd3, 5'd17, 5'd12};
        idle_list = '{0, 79, 0, 15};
        stall_list = '{0, 0, 79, 15};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_angle = '0;
        i_stall = 1'b0;
        tc_shadow = sts_pkg::TC_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, zero, exact 2*pi and its neighbors, small magnitudes.
        angle_q = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00000001,
                    32'd105414357, 32'd105414356, 32'd105414358, -32'sd105414357,
                    -32'sd105414358, 32'd52707179, 32'd26353589, 32'd79060768,
                    32'h55555555, 32'hAAAAAAAA, 32'd210828714, 32'd210828715};
        drain_results();
        apb_write(3'(4 * sts_pkg::REG_TERM_COUNT), 32'd16);
        angle_q = '{32'h7FFFFFFF, 32'h80000000, 32'd105414357, 32'd100000000,
                    32'hFFFFFFFF, 32'd79060768};
        drain_results();

        for (int p = 0; p < 8; p++) begin
            apb_write(3'(4 * sts_pkg::REG_TERM_COUNT),
                      (p == 3) ? 32'hFFFFFFFF : 32'(tc_list[p]));
            send_idle_pct = idle_list[p % 4];
            recv_stall_pct = stall_list[p % 4];
            for (int j = 0; j < 228; j++) angle_q.push_back(random_angle());
            drain_results();
        end

        stim_done = 1'b1;
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
